>>> rtl/indexed_min_heap_decrease_key_core_assert.svh
// ----------------------------------------------------------------------------
// indexed min-heap assertion macros
// concurrent checks clocked by i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_CORE_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define IHDK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IHDK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IHDK_ASSERT_IMP(lbl, ante, cons)
`define IHDK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/ihdk_pkg.sv
// ----------------------------------------------------------------------------
// ihdk_pkg
// shared constants, request and status codes of the indexed min-heap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihdk_pkg;
    localparam int GRID_EDGE_DEF = 16;
    localparam int COST_BITS_DEF = 24;
    localparam int COORD_W       = 4;
    localparam int PORT_COST_W   = 24;
    localparam int COUNT_W       = 13;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;

    localparam int IN_X_LSB   = 0;
    localparam int IN_Y_LSB   = 4;
    localparam int IN_Z_LSB   = 8;
    localparam int IN_G_LSB   = 12;
    localparam int IN_H_LSB   = 36;
    localparam int IN_DATA_W  = 64;

    localparam int OUT_F_LSB   = 60;
    localparam int OUT_CNT_LSB = 84;
    localparam int OUT_DATA_W  = 104;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_EXTRACT  = 2'd1,
        REQ_DECREASE = 2'd2,
        REQ_NOP      = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;
endpackage

`default_nettype wire

>>> rtl/indexed_min_heap_decrease_key_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_core
// indexed binary min-heap on f = g + h with insert, extract-min, decrease-key
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (tuser = request kind, tdata = point
// and costs); each request gives exactly one response on the m_axis channel
// (tuser = status, tdata = extracted entry and entry count).
// Heap entries live in one ram indexed by slot, the slot of every grid point
// in a second ram. One request is processed at a time by a sequencer:
// insert climbs from the new last slot, extract moves the last entry to the
// root and descends, and decrease climbs and then descends. Each parent or
// child visited costs one access to the single read port of the heap ram.
// After reset every entry of the position ram is swept to zero, during
// which s_axis_tready stays low. The response sits in an output register;
// the next request is accepted while it waits, and the sequencer holds its
// following response until m_axis_tready takes the pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap_decrease_key_core #(
    parameter int GRID_EDGE = ihdk_pkg::GRID_EDGE_DEF,
    parameter int COST_BITS = ihdk_pkg::COST_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point_x, point_y, point_z, cost_from_start, cost_estimate
    input  logic [ihdk_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [ihdk_pkg::REQ_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_x, out_y, out_z, out_g, out_h, out_f, entry_count
    output logic [ihdk_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [ihdk_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import ihdk_pkg::*;

    localparam int NPOINTS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int KW      = $clog2(NPOINTS);
    localparam int SW      = $clog2(NPOINTS + 1);
    localparam int CW      = SW + 1;
    localparam int EW      = 3 * COORD_W + 2 * COST_BITS;
    localparam int OFF_G   = COST_BITS;
    localparam int OFF_Z   = 2 * COST_BITS;
    localparam int OFF_Y   = OFF_Z + COORD_W;
    localparam int OFF_X   = OFF_Y + COORD_W;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_INS_POS  = 15'b000000000000100,
        S_DEC_POS  = 15'b000000000001000,
        S_DEC_ENT  = 15'b000000000010000,
        S_EXT_ROOT = 15'b000000000100000,
        S_EXT_LAST = 15'b000000001000000,
        S_UP_ISSUE = 15'b000000010000000,
        S_UP_CMP   = 15'b000000100000000,
        S_DN_ISSUE = 15'b000001000000000,
        S_DN_L     = 15'b000010000000000,
        S_DN_R     = 15'b000100000000000,
        S_DN_CMP   = 15'b001000000000000,
        S_PLACE    = 15'b010000000000000,
        S_FINISH   = 15'b100000000000000
    } t_state;

    function automatic logic [COST_BITS-1:0] f_of(input logic [EW-1:0] e);
        logic [COST_BITS:0] s;
        s = {1'b0, e[OFF_G +: COST_BITS]} + {1'b0, e[0 +: COST_BITS]};
        f_of = s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
    endfunction

    function automatic logic [KW-1:0] key_of(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z);
        key_of = KW'((32'(x) * GRID_EDGE + 32'(y)) * GRID_EDGE + 32'(z));
    endfunction

    function automatic logic [KW-1:0] key_ent(input logic [EW-1:0] e);
        key_ent = key_of(e[OFF_X +: COORD_W], e[OFF_Y +: COORD_W], e[OFF_Z +: COORD_W]);
    endfunction

    // request fields
    logic [COORD_W-1:0]   in_x, in_y, in_z;
    logic [COST_BITS-1:0] in_g, in_h;
    logic                 in_valid;
    logic [KW-1:0]        in_key;
    logic [EW-1:0]        in_ent;
    t_req                 in_req;

    assign in_x     = s_axis_tdata[IN_X_LSB +: COORD_W];
    assign in_y     = s_axis_tdata[IN_Y_LSB +: COORD_W];
    assign in_z     = s_axis_tdata[IN_Z_LSB +: COORD_W];
    assign in_g     = COST_BITS'(s_axis_tdata[IN_G_LSB +: PORT_COST_W]);
    assign in_h     = COST_BITS'(s_axis_tdata[IN_H_LSB +: PORT_COST_W]);
    assign in_req   = t_req'(s_axis_tuser);
    assign in_valid = (32'(in_x) < GRID_EDGE) && (32'(in_y) < GRID_EDGE)
                      && (32'(in_z) < GRID_EDGE);
    assign in_key   = key_of(in_x, in_y, in_z);
    assign in_ent   = {in_x, in_y, in_z, in_g, in_h};

    // state
    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    t_status              r_status, n_status;
    logic [COST_BITS-1:0] r_g, n_g;
    logic [EW-1:0]        r_ent, n_ent;
    logic [EW-1:0]        r_child, n_child;
    logic [EW-1:0]        r_res, n_res;
    logic [SW-1:0]        r_slot, n_slot;
    logic [SW-1:0]        r_c, n_c;
    logic [SW-1:0]        r_size, n_size;
    logic [KW-1:0]        r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [STATUS_W-1:0]  r_out_user, n_out_user;

    // memory ports
    logic          heap_we, heap_re;
    logic [SW-1:0] heap_waddr, heap_raddr;
    logic [EW-1:0] heap_wdata, heap_rdata;
    logic          pos_we, pos_re;
    logic [KW-1:0] pos_waddr;
    logic [SW-1:0] pos_wdata, pos_rdata;

    ihdk_ram #(.WIDTH(EW), .DEPTH(NPOINTS + 1)) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (heap_we),
        .i_waddr(heap_waddr),
        .i_wdata(heap_wdata),
        .i_re   (heap_re),
        .i_raddr(heap_raddr),
        .o_rdata(heap_rdata)
    );

    ihdk_ram #(.WIDTH(SW), .DEPTH(NPOINTS)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_waddr(pos_waddr),
        .i_wdata(pos_wdata),
        .i_re   (pos_re),
        .i_raddr(in_key),
        .o_rdata(pos_rdata)
    );

    logic [SW-1:0] par;
    logic [CW-1:0] c2, c2p1, size_c;
    logic          is_dec;

    assign par    = r_slot >> 1;
    assign c2     = {r_slot, 1'b0};
    assign c2p1   = {r_slot, 1'b1};
    assign size_c = {1'b0, r_size};
    assign is_dec = (r_req == REQ_DECREASE);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_status    = r_status;
        n_g         = r_g;
        n_ent       = r_ent;
        n_child     = r_child;
        n_res       = r_res;
        n_slot      = r_slot;
        n_c         = r_c;
        n_size      = r_size;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        heap_we     = 1'b0;
        heap_waddr  = r_slot;
        heap_wdata  = r_ent;
        heap_re     = 1'b0;
        heap_raddr  = r_slot;
        pos_we      = 1'b0;
        pos_waddr   = key_ent(r_ent);
        pos_wdata   = r_slot;
        pos_re      = 1'b0;
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                pos_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == KW'(NPOINTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_req    = in_req;
                    n_g      = in_g;
                    n_ent    = in_ent;
                    n_res    = '0;
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                    unique case (in_req)
                        REQ_INSERT: begin
                            if (!in_valid) begin
                                n_status = ST_ABSENT;
                            end else begin
                                pos_re  = 1'b1;
                                n_state = S_INS_POS;
                            end
                        end
                        REQ_EXTRACT: begin
                            if (r_size == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                heap_re    = 1'b1;
                                heap_raddr = SW'(1);
                                n_state    = S_EXT_ROOT;
                            end
                        end
                        REQ_DECREASE: begin
                            if (!in_valid) begin
                                n_status = ST_ABSENT;
                            end else begin
                                pos_re  = 1'b1;
                                n_state = S_DEC_POS;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_INS_POS: begin
                if (pos_rdata != '0) begin
                    n_state = S_FINISH;
                end else if (r_size == SW'(NPOINTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_FINISH;
                end else begin
                    n_size  = r_size + 1'b1;
                    n_slot  = r_size + 1'b1;
                    n_state = S_UP_ISSUE;
                end
            end
            S_DEC_POS: begin
                if (pos_rdata == '0 || pos_rdata > r_size) begin
                    n_status = ST_ABSENT;
                    n_state  = S_FINISH;
                end else begin
                    n_slot     = pos_rdata;
                    heap_re    = 1'b1;
                    heap_raddr = pos_rdata;
                    n_state    = S_DEC_ENT;
                end
            end
            S_DEC_ENT: begin
                n_ent = heap_rdata;
                n_ent[OFF_G +: COST_BITS] = r_g;
                n_state = S_UP_ISSUE;
            end
            S_EXT_ROOT: begin
                n_res     = heap_rdata;
                pos_we    = 1'b1;
                pos_waddr = key_ent(heap_rdata);
                pos_wdata = '0;
                n_size    = r_size - 1'b1;
                if (r_size > SW'(1)) begin
                    heap_re    = 1'b1;
                    heap_raddr = r_size;
                    n_state    = S_EXT_LAST;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_EXT_LAST: begin
                n_ent   = heap_rdata;
                n_slot  = SW'(1);
                n_state = S_DN_ISSUE;
            end
            S_UP_ISSUE: begin
                if (r_slot > SW'(1)) begin
                    heap_re    = 1'b1;
                    heap_raddr = par;
                    n_state    = S_UP_CMP;
                end else begin
                    n_state = is_dec ? S_DN_ISSUE : S_PLACE;
                end
            end
            S_UP_CMP: begin
                if (f_of(heap_rdata) > f_of(r_ent)) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = key_ent(heap_rdata);
                    n_slot     = par;
                    if (par > SW'(1)) begin
                        heap_re    = 1'b1;
                        heap_raddr = par >> 1;
                    end else begin
                        n_state = is_dec ? S_DN_ISSUE : S_PLACE;
                    end
                end else begin
                    n_state = is_dec ? S_DN_ISSUE : S_PLACE;
                end
            end
            S_DN_ISSUE: begin
                if (c2 > size_c) begin
                    n_state = S_PLACE;
                end else begin
                    heap_re    = 1'b1;
                    heap_raddr = c2[SW-1:0];
                    n_state    = S_DN_L;
                end
            end
            S_DN_L: begin
                n_child = heap_rdata;
                n_c     = c2[SW-1:0];
                if (c2p1 <= size_c) begin
                    heap_re    = 1'b1;
                    heap_raddr = c2p1[SW-1:0];
                    n_state    = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                if (f_of(heap_rdata) < f_of(r_child)) begin
                    n_child = heap_rdata;
                    n_c     = r_c + 1'b1;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (f_of(r_child) < f_of(r_ent)) begin
                    heap_we    = 1'b1;
                    heap_wdata = r_child;
                    pos_we     = 1'b1;
                    pos_waddr  = key_ent(r_child);
                    n_slot     = r_c;
                    n_state    = S_DN_ISSUE;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_status;
                    n_out_data  = OUT_DATA_W'({
                        COUNT_W'(r_size),
                        PORT_COST_W'(f_of(r_res)),
                        PORT_COST_W'(r_res[0 +: COST_BITS]),
                        PORT_COST_W'(r_res[OFF_G +: COST_BITS]),
                        r_res[OFF_Z +: COORD_W],
                        r_res[OFF_Y +: COORD_W],
                        r_res[OFF_X +: COORD_W]
                    });
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_size      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_status   <= n_status;
        r_g        <= n_g;
        r_ent      <= n_ent;
        r_child    <= n_child;
        r_res      <= n_res;
        r_slot     <= n_slot;
        r_c        <= n_c;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`include "indexed_min_heap_decrease_key_core_assert.svh"

    `IHDK_ASSERT_IMP(a_size_bound, 1'b1, r_size <= SW'(NPOINTS))
    `IHDK_ASSERT_IMP(a_empty_count, m_axis_tvalid && m_axis_tuser == ST_EMPTY, m_axis_tdata[OUT_CNT_LSB +: COUNT_W] == '0)
    `IHDK_ASSERT_IMP(a_err_no_entry, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[OUT_CNT_LSB-1:0] == '0)
    `IHDK_ASSERT_IMP(a_heap_rw_apart, heap_we && heap_re, heap_waddr != heap_raddr)
    `IHDK_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

`default_nettype wire

>>> rtl/ihdk_ram.sv
// ----------------------------------------------------------------------------
// ihdk_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire
